// ===== design/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types, constants and helpers of the keyboard scancode translator.
// ----------------------------------------------------------------------------
package kst_pkg;

	localparam int KEY_COUNT = 128;
	localparam int KEY_W     = (KEY_COUNT > 2) ? $clog2(KEY_COUNT) : 1;
	localparam int ADDR_W    = KEY_W + 2;
	localparam int MEM_DEPTH = KEY_COUNT * 4;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	// input item kinds (tuser)
	localparam logic ACT_TRANSLATE = 1'b0;
	localparam logic ACT_WRITE     = 1'b1;

	// queue operation kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_CTRL_CODE   = 3'd0;
	localparam logic [2:0] REG_LSHIFT_CODE = 3'd1;
	localparam logic [2:0] REG_RSHIFT_CODE = 3'd2;
	localparam logic [2:0] REG_CAPS_CODE   = 3'd3;
	localparam logic [2:0] REG_ALT_MODE    = 3'd4;

	localparam logic [7:0] BYTE_HIGH  = 8'h80;
	localparam logic [7:0] BYTE_ESC   = 8'h9b;
	localparam logic [7:0] BYTE_QMARK = 8'h3f;
	localparam logic [7:0] BYTE_LC_A  = 8'h61;
	localparam logic [7:0] BYTE_LC_Z  = 8'h7a;
	localparam logic [7:0] CASE_DIFF  = 8'h20;
	localparam logic [7:0] ALT_OFFSET = 8'h40;
	localparam logic [7:0] ESC_LAST   = 8'h88;

	typedef struct packed {
		logic [6:0] ctrl_code;
		logic [6:0] left_shift_code;
		logic [6:0] right_shift_code;
		logic [6:0] caps_code;
		logic       alt_mode;
	} cfg_t;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        value;
		logic              upcase;
		logic              oob;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} push_t;

	function automatic logic [7:0] esc_letter(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h50; // P
			3'd1: ch = 8'h51; // Q
			3'd2: ch = 8'h52; // R
			3'd3: ch = 8'h53; // S
			3'd4: ch = 8'h41; // A
			3'd5: ch = 8'h42; // B
			3'd6: ch = 8'h43; // C
			default: ch = 8'h44; // D
		endcase
		return ch;
	endfunction

endpackage

// ===== design/kst_front.sv =====
// ----------------------------------------------------------------------------
// kst_front
// Accepts input requests, tracks the modifier keys and queues table work.
// ----------------------------------------------------------------------------
module kst_front (
	input  logic              clk,
	input  logic              arst_n,
	input  kst_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_action,
	input  logic [7:0]        in_key_byte,
	input  logic [6:0]        in_entry_key,
	input  logic [1:0]        in_entry_layer,
	input  logic [7:0]        in_entry_value,
	input  logic              q_full,
	output kst_pkg::push_t    q_push
);

	logic ctrl_down_q;
	logic shift_down_q;
	logic caps_on_q;

	logic       accept;
	logic       press;
	logic [6:0] key;
	logic       is_ctrl;
	logic       is_shift;
	logic       is_caps;
	logic       key_in_range;
	logic       entry_in_range;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign press    = !in_key_byte[7];
	assign key      = in_key_byte[6:0];

	// priority: control, then either shift, then caps lock
	assign is_ctrl  = (key == cfg.ctrl_code);
	assign is_shift = !is_ctrl && ((key == cfg.left_shift_code) ||
		(key == cfg.right_shift_code));
	assign is_caps  = !is_ctrl && !is_shift && (key == cfg.caps_code);

	assign key_in_range   = (8'(key) < 8'(kst_pkg::KEY_COUNT));
	assign entry_in_range = (8'(in_entry_key) < 8'(kst_pkg::KEY_COUNT));

	always_comb begin
		q_push = '0;
		if (in_action == kst_pkg::ACT_WRITE) begin
			q_push.push         = accept && entry_in_range;
			q_push.entry.op     = kst_pkg::OP_WRITE;
			q_push.entry.addr   = {in_entry_key[kst_pkg::KEY_W-1:0], in_entry_layer};
			q_push.entry.value  = in_entry_value;
		end else begin
			q_push.push         = accept && press && !is_ctrl && !is_shift && !is_caps;
			q_push.entry.op     = kst_pkg::OP_READ;
			q_push.entry.addr   = {key[kst_pkg::KEY_W-1:0], ctrl_down_q, shift_down_q};
			q_push.entry.upcase = caps_on_q && !ctrl_down_q && !shift_down_q;
			q_push.entry.oob    = !key_in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_down_q  <= 1'b0;
			shift_down_q <= 1'b0;
			caps_on_q    <= 1'b0;
		end else if (accept && (in_action == kst_pkg::ACT_TRANSLATE)) begin
			if (is_ctrl) begin
				ctrl_down_q <= press;
			end
			if (is_shift) begin
				shift_down_q <= press;
			end
			// toggle on release
			if (is_caps && !press) begin
				caps_on_q <= !caps_on_q;
			end
		end
	end

endmodule

// ===== design/kst_fifo.sv =====
// ----------------------------------------------------------------------------
// kst_fifo
// Short queue between the classifying front and the table/output back end.
// ----------------------------------------------------------------------------
module kst_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  kst_pkg::push_t   push,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output kst_pkg::entry_t  head
);

	kst_pkg::entry_t                  slot_q [kst_pkg::FIFO_DEPTH];
	logic [kst_pkg::FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [kst_pkg::FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [kst_pkg::FIFO_CNT_W-1:0]   count_q;

	assign full  = (count_q == kst_pkg::FIFO_CNT_W'(kst_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.push) begin
			slot_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push.push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> !full) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");

endmodule

// ===== design/kst_back.sv =====
// ----------------------------------------------------------------------------
// kst_back
// Owns the key table: applies queued writes, reads entries for key presses
// and expands each value into one to three output bytes.
// ----------------------------------------------------------------------------
module kst_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             alt_mode,
	input  logic             q_empty,
	input  kst_pkg::entry_t  q_head,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last
);

	logic [7:0] mem_q [kst_pkg::MEM_DEPTH];

	// stage 1: table read data
	logic       valid_s1;
	logic [7:0] rdata_s1;
	logic       upcase_s1;
	logic       oob_s1;

	// stage 2: expanded byte run
	logic       valid_s2;
	logic [1:0] pos_s2;
	logic [1:0] cnt_s2;
	logic [7:0] b0_s2;
	logic [7:0] b1_s2;
	logic [7:0] b2_s2;

	logic       out_take;
	logic       s2_free;
	logic       s1_move;
	logic       s1_free;
	logic [7:0] v;
	logic [7:0] nb0;
	logic [7:0] nb1;
	logic [7:0] nb2;
	logic [1:0] ncnt;

	assign out_valid = valid_s2;
	assign out_last  = ((pos_s2 + 2'd1) == cnt_s2);
	assign out_take  = valid_s2 && out_ready;
	assign s2_free   = !valid_s2 || (out_take && out_last);
	assign s1_move   = valid_s1 && s2_free;
	assign s1_free   = !valid_s1 || s1_move;
	assign q_pop     = !q_empty && s1_free;

	always_comb begin
		case (pos_s2)
			2'd0:    out_byte = b0_s2;
			2'd1:    out_byte = b1_s2;
			default: out_byte = b2_s2;
		endcase
	end

	// value after caps lock, then its byte run
	always_comb begin
		v = oob_s1 ? 8'h00 : rdata_s1;
		if (upcase_s1 && (v >= kst_pkg::BYTE_LC_A) && (v <= kst_pkg::BYTE_LC_Z)) begin
			v = v - kst_pkg::CASE_DIFF;
		end
		nb0  = v;
		nb1  = kst_pkg::esc_letter(v[2:0] - 3'd1);
		nb2  = v - kst_pkg::ALT_OFFSET;
		ncnt = 2'd1;
		if (!v[7] || (v == kst_pkg::BYTE_HIGH)) begin
			ncnt = 2'd1;
		end else if (v <= kst_pkg::ESC_LAST) begin
			nb0  = kst_pkg::BYTE_ESC;
			ncnt = 2'd2;
		end else if (alt_mode) begin
			nb0  = kst_pkg::BYTE_ESC;
			nb1  = kst_pkg::BYTE_QMARK;
			ncnt = 2'd3;
		end else begin
			nb0  = {1'b0, v[6:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && (q_head.op == kst_pkg::OP_WRITE)) begin
			mem_q[q_head.addr] <= q_head.value;
		end
		if (q_pop && (q_head.op == kst_pkg::OP_READ)) begin
			rdata_s1  <= mem_q[q_head.addr];
			upcase_s1 <= q_head.upcase;
			oob_s1    <= q_head.oob;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			cnt_s2 <= ncnt;
			b0_s2  <= nb0;
			b1_s2  <= nb1;
			b2_s2  <= nb2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pos_s2   <= '0;
		end else begin
			if (q_pop) begin
				valid_s1 <= (q_head.op == kst_pkg::OP_READ);
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				valid_s2 <= 1'b1;
				pos_s2   <= '0;
			end else if (out_take) begin
				if (out_last) begin
					valid_s2 <= 1'b0;
				end else begin
					pos_s2 <= pos_s2 + 2'd1;
				end
			end
		end
	end

	a_pos_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (pos_s2 < cnt_s2)) else $error("byte position past run");
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && (q_head.op == kst_pkg::OP_READ)) |=> valid_s1)
		else $error("table read lost");

endmodule

// ===== design/keyboard_scancode_to_ascii.sv =====
// ----------------------------------------------------------------------------
// keyboard_scancode_to_ascii
// Raw keyboard byte to character stream translator with loadable key table.
// ----------------------------------------------------------------------------
// Each input request either writes one key table entry or translates one raw
// keyboard byte. The input side takes a request every cycle while its four-
// entry queue has room; modifier keys, releases and table writes produce no
// output. A key press emits one to three bytes on the output, one byte per
// cycle while the output is ready (one byte for plain characters, two for
// ESC pairs, three for alt escapes); the output port is the limit. The first
// byte goes through the queue write, the single-port table read register and
// the expansion register in that order; each holds while the one after it is busy.
// The table memory does one write or one read per cycle and is undefined
// until written.
module keyboard_scancode_to_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] key_byte, [14:8] entry_key, [16:15] entry_layer, [24:17] entry_value
	input  logic [31:0] s_axis_tdata,
	// [0] action
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] out_byte
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast
);

	kst_pkg::cfg_t   cfg_q;
	kst_pkg::push_t  q_push;
	kst_pkg::entry_t q_head;
	logic            q_full;
	logic            q_empty;
	logic            q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ctrl_code        <= 7'd0;
			cfg_q.left_shift_code  <= 7'd1;
			cfg_q.right_shift_code <= 7'd2;
			cfg_q.caps_code        <= 7'd3;
			cfg_q.alt_mode         <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				kst_pkg::REG_CTRL_CODE:   cfg_q.ctrl_code        <= cfg_data;
				kst_pkg::REG_LSHIFT_CODE: cfg_q.left_shift_code  <= cfg_data;
				kst_pkg::REG_RSHIFT_CODE: cfg_q.right_shift_code <= cfg_data;
				kst_pkg::REG_CAPS_CODE:   cfg_q.caps_code        <= cfg_data;
				kst_pkg::REG_ALT_MODE:    cfg_q.alt_mode         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	kst_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.in_action      (s_axis_tuser[0]),
		.in_key_byte    (s_axis_tdata[7:0]),
		.in_entry_key   (s_axis_tdata[14:8]),
		.in_entry_layer (s_axis_tdata[16:15]),
		.in_entry_value (s_axis_tdata[24:17]),
		.q_full         (q_full),
		.q_push         (q_push)
	);

	kst_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.head   (q_head)
	);

	kst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.alt_mode  (cfg_q.alt_mode),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
